// ===== rtl/graph_articulation_points_core_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the articulation point core
// ----------------------------------------------------------------------------
`ifndef GRAPH_ARTICULATION_POINTS_CORE_MACROS_SVH
`define GRAPH_ARTICULATION_POINTS_CORE_MACROS_SVH
// implication checked every clock, disabled in reset
`define GAP_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication, disabled in reset
`define GAP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ===== rtl/gap_pkg.sv =====
// ----------------------------------------------------------------------------
// gap_pkg
// shared constants and types of the articulation point core
// ----------------------------------------------------------------------------
`default_nettype none
package gap_pkg;
   localparam int MaxVertices = 64;
   localparam int MaxEdges    = 1024;
   localparam int VW          = 6;
   localparam int EW          = 10;
   localparam int TW          = 7;
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_RUN   = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/gap_edge_ram.sv =====
// ----------------------------------------------------------------------------
// gap_edge_ram
// edge store: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module gap_edge_ram
   import gap_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [EW-1:0]   wr_addr,
   input  wire logic [2*VW-1:0] wr_data,
   input  wire logic [EW-1:0]   rd_addr,
   output logic [2*VW-1:0]      rd_data
);
   logic [2*VW-1:0] mem [MaxEdges];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/graph_articulation_points_core.sv =====
// ----------------------------------------------------------------------------
// graph_articulation_points_core
// Tarjan articulation point search over a loaded undirected edge list
// ----------------------------------------------------------------------------
// Usage: req transactions with tuser=0 load one edge (tdata = first and second
// endpoint); an edge with an endpoint >= vertex count or beyond 1024 stored
// edges is dropped and a sticky flag is set. Loads are accepted while idle and
// can follow back to back.
// A transaction with tuser=1 runs a depth-first search over all components
// and then emits one rsp transaction per vertex in ascending order, tlast on
// the final vertex. Search state sits in two memories with registered reads:
// a per-vertex record (discovery time, low link, parent) and the search
// stack. Each step re-reads the stack top and its vertex record through the
// states ST_TOP, ST_FETCH and ST_UREC, then scans the edge store, issuing a
// read for each entry and checking it when the data returns.
// One item is handled at a time; req_tready is low from the run until the
// last result is taken. If rsp_tready is low the current result holds.
// Reset (synchronous, active high) empties the edge store, clears the drop
// flag and sets the vertex count to 64; no clearing pass is needed.
// After a run the edge store is empty again.
// ----------------------------------------------------------------------------
`default_nettype none
module graph_articulation_points_core
   import gap_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data,     // vertex_count
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,       // [5:0] first end, [11:6] second end
   input  wire logic        req_tuser,       // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,       // [5:0] vertex_index, [6] is_cut_vertex
   output logic             rsp_tuser,       // edges_dropped
   output logic             rsp_tlast
);
`include "graph_articulation_points_core_macros.svh"

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_INIT  = 12'b000000000010,
      ST_ROOT  = 12'b000000000100,
      ST_TOP   = 12'b000000001000,
      ST_FETCH = 12'b000000010000,
      ST_UREC  = 12'b000000100000,
      ST_SCAN  = 12'b000001000000,
      ST_VISIT = 12'b000010000000,
      ST_BACK  = 12'b000100000000,
      ST_POP   = 12'b001000000000,
      ST_JOIN  = 12'b010000000000,
      ST_EMIT  = 12'b100000000000
   } state_type;

   typedef struct packed {
      logic          hasp;
      logic [VW-1:0] par;
      logic [TW-1:0] low;
      logic [TW-1:0] disc;
   } vrec_type;

   typedef struct packed {
      logic [EW:0]   pos;
      logic [VW-1:0] vtx;
   } frame_type;

   state_type         state_ff;
   logic [6:0]        vcount_ff;
   logic [EW:0]       etotal_ff;
   logic              drop_ff;
   logic [TW-1:0]     time_ff;
   logic [VW-1:0]     root_ff, u_ff, v_ff, i_ff;
   logic [VW:0]       sp_ff;
   logic [EW:0]       e_ff;
   logic [1:0]        rchild_ff;
   logic              rd_pend_ff;

   // record of the vertex on top of the stack
   logic [TW-1:0]     u_low_ff, u_disc_ff;
   logic [VW-1:0]     u_par_ff;
   logic              u_hasp_ff;

   // visited and cut flags, cleared at each run
   logic [MaxVertices-1:0] vis_ff, cut_ff;

   // vertex record memory and search stack memory
   vrec_type          vtx_mem [MaxVertices];
   vrec_type          vtx_rdata, vtx_wdata;
   logic [VW-1:0]     vtx_raddr, vtx_waddr;
   logic              vtx_we;
   frame_type         stk_mem [MaxVertices];
   frame_type         stk_rdata, stk_wdata;
   logic [VW-1:0]     stk_waddr;
   logic              stk_we;

   logic [6:0]        n_c;
   logic [VW-1:0]     ea, eb;
   logic [2*VW-1:0]   rd_data;
   logic [EW-1:0]     rd_addr;
   logic              ld_ok;
   logic [VW-1:0]     top_idx;
   logic [TW-1:0]     t_next;
   logic              scan_hit;

   // effective vertex count
   always_comb begin
      n_c = vcount_ff;
      if (vcount_ff == 7'd0) n_c = 7'd1;
      if (vcount_ff > 7'(MaxVertices)) n_c = 7'(MaxVertices);
   end

   assign ld_ok = (7'(req_tdata[5:0]) < n_c) && (7'(req_tdata[11:6]) < n_c)
                  && (etotal_ff < (EW+1)'(MaxEdges));
   assign req_tready = (state_ff == ST_IDLE);
   assign rd_addr = e_ff[EW-1:0];
   assign ea = rd_data[VW-1:0];
   assign eb = rd_data[2*VW-1:VW];
   assign top_idx = sp_ff[VW-1:0] - VW'(1);
   assign t_next = time_ff + 1'b1;
   assign scan_hit = rd_pend_ff && 7'(ea) < n_c && 7'(eb) < n_c && ea != eb
                     && (ea == u_ff || eb == u_ff);

   gap_edge_ram u_ram (
      .clock   (clock),
      .wr_en   (req_tvalid && req_tready && req_tuser == CMD_LOAD && ld_ok),
      .wr_addr (etotal_ff[EW-1:0]),
      .wr_data (req_tdata[11:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // vertex record memory, registered read
   always_ff @(posedge clock) begin
      if (vtx_we) vtx_mem[vtx_waddr] <= vtx_wdata;
      vtx_rdata <= vtx_mem[vtx_raddr];
   end

   // search stack memory, registered read of the top entry
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_rdata <= stk_mem[top_idx];
   end

   // vertex record read address
   always_comb begin
      case (state_ff)
         ST_FETCH: vtx_raddr = stk_rdata.vtx;
         ST_VISIT: vtx_raddr = v_ff;
         ST_POP:   vtx_raddr = u_par_ff;
         default:  vtx_raddr = '0;
      endcase
   end

   // memory writes; the sequencing keeps each read of an entry behind any write
   // to that entry
   always_comb begin
      vtx_we    = 1'b0;
      vtx_waddr = '0;
      vtx_wdata = '0;
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      case (state_ff)
         ST_ROOT: begin
            if (7'(root_ff) < n_c && !vis_ff[root_ff]) begin
               vtx_we    = 1'b1;
               vtx_waddr = root_ff;
               vtx_wdata = {1'b0, {VW{1'b0}}, t_next, t_next};
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = {{(EW+1){1'b0}}, root_ff};
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               stk_we    = 1'b1;
               stk_waddr = top_idx;
               stk_wdata = {e_ff + 1'b1, u_ff};
            end
         end
         ST_VISIT: begin
            if (!vis_ff[v_ff]) begin
               vtx_we    = 1'b1;
               vtx_waddr = v_ff;
               vtx_wdata = {1'b1, u_ff, t_next, t_next};
               if (sp_ff < 7'(MaxVertices)) begin
                  stk_we    = 1'b1;
                  stk_waddr = sp_ff[VW-1:0];
                  stk_wdata = {{(EW+1){1'b0}}, v_ff};
               end
            end
         end
         ST_BACK: begin
            if (vtx_rdata.disc < u_low_ff) begin
               vtx_we    = 1'b1;
               vtx_waddr = u_ff;
               vtx_wdata = {u_hasp_ff, u_par_ff, vtx_rdata.disc, u_disc_ff};
            end
         end
         ST_JOIN: begin
            if (u_low_ff < vtx_rdata.low) begin
               vtx_we    = 1'b1;
               vtx_waddr = u_par_ff;
               vtx_wdata = {vtx_rdata.hasp, vtx_rdata.par, u_low_ff, vtx_rdata.disc};
            end
         end
         default: begin
         end
      endcase
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= 7'd64;
         etotal_ff <= '0;
         drop_ff   <= 1'b0;
         rsp_tvalid <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         if (csr_wr_en) vcount_ff <= csr_wr_data;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  if (req_tuser == CMD_LOAD) begin
                     if (ld_ok) etotal_ff <= etotal_ff + 1'b1;
                     else drop_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_INIT;
                  end
               end
            end
            ST_INIT: begin
               vis_ff  <= '0;
               cut_ff  <= '0;
               time_ff <= '0;
               root_ff <= '0;
               sp_ff   <= '0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (7'(root_ff) >= n_c) begin
                  state_ff <= ST_EMIT;
                  i_ff <= '0;
               end else if (vis_ff[root_ff]) begin
                  if (7'(root_ff) == n_c - 7'd1) begin
                     state_ff <= ST_EMIT;
                     i_ff <= '0;
                  end else root_ff <= root_ff + 1'b1;
               end else begin
                  vis_ff[root_ff] <= 1'b1;
                  time_ff <= t_next;
                  sp_ff <= 7'd1;
                  rchild_ff <= '0;
                  state_ff <= ST_TOP;
               end
            end
            ST_TOP: begin
               if (sp_ff == '0) begin
                  if (rchild_ff > 2'd1) cut_ff[root_ff] <= 1'b1;
                  state_ff <= ST_ROOT;
               end else begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               // stack top is valid, vertex record read is issued
               u_ff <= stk_rdata.vtx;
               e_ff <= stk_rdata.pos;
               state_ff <= ST_UREC;
            end
            ST_UREC: begin
               u_low_ff  <= vtx_rdata.low;
               u_disc_ff <= vtx_rdata.disc;
               u_par_ff  <= vtx_rdata.par;
               u_hasp_ff <= vtx_rdata.hasp;
               rd_pend_ff <= 1'b0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               // read issued at e_ff; data is checked while rd_pend_ff is set
               if (!rd_pend_ff) begin
                  if (e_ff >= etotal_ff) state_ff <= ST_POP;
                  else rd_pend_ff <= 1'b1;
               end else begin
                  rd_pend_ff <= 1'b0;
                  e_ff <= e_ff + 1'b1;
                  if (scan_hit) begin
                     v_ff <= (ea == u_ff) ? eb : ea;
                     state_ff <= ST_VISIT;
                  end
               end
            end
            ST_VISIT: begin
               if (!vis_ff[v_ff]) begin
                  if (u_ff == root_ff && rchild_ff != 2'd3)
                     rchild_ff <= rchild_ff + 1'b1;
                  vis_ff[v_ff] <= 1'b1;
                  time_ff <= t_next;
                  if (sp_ff < 7'(MaxVertices)) sp_ff <= sp_ff + 1'b1;
                  state_ff <= ST_TOP;
               end else if (!(u_hasp_ff && v_ff == u_par_ff)) begin
                  state_ff <= ST_BACK;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_BACK: begin
               // back edge: discovery time of the neighbor is valid
               if (vtx_rdata.disc < u_low_ff) u_low_ff <= vtx_rdata.disc;
               state_ff <= ST_SCAN;
            end
            ST_POP: begin
               sp_ff <= sp_ff - 1'b1;
               if (sp_ff > 7'd1) state_ff <= ST_JOIN;
               else state_ff <= ST_TOP;
            end
            ST_JOIN: begin
               // parent record is valid
               if (u_par_ff != root_ff && u_low_ff >= vtx_rdata.disc)
                  cut_ff[u_par_ff] <= 1'b1;
               state_ff <= ST_TOP;
            end
            ST_EMIT: begin
               if (!rsp_tvalid) begin
                  rsp_tvalid <= 1'b1;
                  rsp_tdata  <= {1'b0, cut_ff[i_ff], i_ff};
                  rsp_tuser  <= drop_ff;
                  rsp_tlast  <= (7'(i_ff) == n_c - 7'd1);
               end else if (rsp_tready) begin
                  rsp_tvalid <= 1'b0;
                  if (rsp_tlast) begin
                     etotal_ff <= '0;
                     drop_ff   <= 1'b0;
                     state_ff  <= ST_IDLE;
                  end else i_ff <= i_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `GAP_ASSERT_IMP(a_tvalid_only_emit, clock, reset, rsp_tvalid, state_ff == ST_EMIT)
   `GAP_ASSERT_IMP(a_etotal_cap, clock, reset, 1'b1, etotal_ff <= (EW+1)'(MaxEdges))
   `GAP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
endmodule
`default_nettype wire
